// ===== sv/fbc_pkg.sv =====
`timescale 1ns / 1ps

package fbc_pkg;

  localparam int MAX_KEY_BYTES_DEF = 8;
  localparam int MAX_ROUNDS_DEF    = 255;

  localparam int BLOCK_W = 64;
  localparam int HALF_W  = 32;
  localparam int KEY_W   = 64;
  localparam int CFG_IDX_W = 2;

  localparam logic [15:0] ROUND_MASK = 16'hE5E5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KEY_BYTES   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT = 2'd2;

  // Operation codes carried with each block.
  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic [3:0] KEY_LENGTH_RST  = 4'd1;
  localparam logic [7:0] ROUND_COUNT_RST = 8'd16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_RUN,
    ST_DONE
  } state_t;

  // Per-round control handed to the round datapath.
  typedef struct packed {
    logic [7:0] key_byte;
    logic [7:0] j;
    logic       last;
  } round_ctl_t;

endpackage

// ===== sv/feistel_block_cipher_64.sv =====
`timescale 1ns / 1ps

// 64-bit Feistel block cipher with a keyword key of up to eight bytes.
// Configuration: cfg_we writes cfg_wdata into register cfg_index (0 key bytes,
// 1 key length, 2 round count) in the same cycle; write only while idle.
// Input: a transaction on in_valid/in_ready carries one block and the
// operation (0 encrypt, 1 decrypt). Output: one transaction on
// out_valid/out_ready carries the processed block.
// Datapath: a single round unit with one 16x16 multiplier does one round per
// cycle. Encryption runs the rounds directly; decryption first finds the
// starting key byte with a remainder unit, then runs the rounds. Zero rounds
// give the block back unchanged. One block is in flight at a time; a new block
// is taken in the cycle its predecessor's result is taken, not before.
// Reset returns the key to zero, key length to 1, round count to 16, and the
// block to idle. A stalled receiver holds the result in the output register
// and the block accepts nothing until it is taken.
module feistel_block_cipher_64 #(
  parameter int MAX_KEY_BYTES = fbc_pkg::MAX_KEY_BYTES_DEF,
  parameter int MAX_ROUNDS    = fbc_pkg::MAX_ROUNDS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fbc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fbc_pkg::KEY_W-1:0]       cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_operation,
  input  logic [fbc_pkg::BLOCK_W-1:0]     in_block_in,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [fbc_pkg::BLOCK_W-1:0]     out_block_out
);

  localparam int IDX_W = (MAX_KEY_BYTES > 1) ? $clog2(MAX_KEY_BYTES) : 1;
  localparam int HW    = fbc_pkg::HALF_W;

  fbc_pkg::state_t state_r, state_nxt;

  logic [fbc_pkg::KEY_W-1:0] key_bytes_r;
  logic [3:0]                key_length_r;
  logic [7:0]                round_count_r;

  logic [HW-1:0]    left_r, left_nxt;
  logic [HW-1:0]    right_r, right_nxt;
  logic             op_r, op_nxt;
  logic [7:0]       j_r, j_nxt;
  logic [7:0]       remain_r, remain_nxt;
  logic [IDX_W-1:0] kidx_r, kidx_nxt;

  logic [3:0]       klen;
  logic [IDX_W-1:0] klen_m1;
  logic [7:0]       nrounds;
  logic             in_fire;
  logic             out_fire;
  logic             mod_start;
  logic             mod_done;
  logic [3:0]       mod_rem;

  fbc_pkg::round_ctl_t rctl;
  logic [HW-1:0]       round_left;
  logic [HW-1:0]       round_right;

  // Clamp the registers into their working ranges.
  always_comb begin
    if (key_length_r == 4'd0) begin
      klen = 4'd1;
    end else if (key_length_r > 4'(MAX_KEY_BYTES)) begin
      klen = 4'(MAX_KEY_BYTES);
    end else begin
      klen = key_length_r;
    end
    if (round_count_r > 8'(MAX_ROUNDS)) begin
      nrounds = 8'(MAX_ROUNDS);
    end else begin
      nrounds = round_count_r;
    end
  end

  assign klen_m1 = IDX_W'(klen - 4'd1);

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_bytes_r   <= '0;
      key_length_r  <= fbc_pkg::KEY_LENGTH_RST;
      round_count_r <= fbc_pkg::ROUND_COUNT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fbc_pkg::REG_KEY_BYTES:   key_bytes_r   <= cfg_wdata;
        fbc_pkg::REG_KEY_LENGTH:  key_length_r  <= cfg_wdata[3:0];
        fbc_pkg::REG_ROUND_COUNT: round_count_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign rctl.key_byte = key_bytes_r[{kidx_r, 3'b000} +: 8];
  assign rctl.j        = j_r;
  assign rctl.last     = (remain_r == 8'd1);

  fbc_round u_round (
    .ctl       (rctl),
    .left      (left_r),
    .right     (right_r),
    .new_left  (round_left),
    .new_right (round_right)
  );

  // Decryption starts at key byte (n - 1) mod key length.
  fbc_keymod u_keymod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (nrounds - 8'd1),
    .divisor  (klen),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      fbc_pkg::ST_IDLE, fbc_pkg::ST_DONE: begin
        if (in_fire) begin
          if (nrounds == 8'd0) begin
            state_nxt = fbc_pkg::ST_DONE;
          end else if (in_operation == fbc_pkg::OP_DECRYPT) begin
            state_nxt = fbc_pkg::ST_MOD;
          end else begin
            state_nxt = fbc_pkg::ST_RUN;
          end
        end else if (out_fire) begin
          state_nxt = fbc_pkg::ST_IDLE;
        end
      end
      fbc_pkg::ST_MOD: begin
        if (mod_done) begin
          state_nxt = fbc_pkg::ST_RUN;
        end
      end
      fbc_pkg::ST_RUN: begin
        if (remain_r == 8'd1) begin
          state_nxt = fbc_pkg::ST_DONE;
        end
      end
      default: state_nxt = fbc_pkg::ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      fbc_pkg::ST_IDLE: in_ready = 1'b1;
      fbc_pkg::ST_DONE: begin
        out_valid = 1'b1;
        in_ready  = out_ready;
      end
      default: ;
    endcase
  end

  assign mod_start     = in_fire && (in_operation == fbc_pkg::OP_DECRYPT) &&
                         (nrounds != 8'd0);
  assign out_block_out = {left_r, right_r};

  // Datapath registers.
  always_comb begin
    left_nxt   = left_r;
    right_nxt  = right_r;
    op_nxt     = op_r;
    j_nxt      = j_r;
    remain_nxt = remain_r;
    kidx_nxt   = kidx_r;
    if (in_fire) begin
      left_nxt   = in_block_in[fbc_pkg::BLOCK_W-1:HW];
      right_nxt  = in_block_in[HW-1:0];
      op_nxt     = in_operation;
      remain_nxt = nrounds;
      j_nxt      = (in_operation == fbc_pkg::OP_DECRYPT) ? (nrounds - 8'd1) : 8'd0;
      kidx_nxt   = '0;
    end else if (state_r == fbc_pkg::ST_MOD) begin
      kidx_nxt = mod_rem[IDX_W-1:0];
    end else if (state_r == fbc_pkg::ST_RUN) begin
      left_nxt   = round_left;
      right_nxt  = round_right;
      remain_nxt = remain_r - 8'd1;
      if (op_r == fbc_pkg::OP_DECRYPT) begin
        j_nxt    = j_r - 8'd1;
        kidx_nxt = (kidx_r == '0) ? klen_m1 : (kidx_r - IDX_W'(1));
      end else begin
        j_nxt    = j_r + 8'd1;
        kidx_nxt = (kidx_r == klen_m1) ? '0 : (kidx_r + IDX_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fbc_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    left_r   <= left_nxt;
    right_r  <= right_nxt;
    op_r     <= op_nxt;
    j_r      <= j_nxt;
    remain_r <= remain_nxt;
    kidx_r   <= kidx_nxt;
  end

endmodule

// ===== sv/fbc_keymod.sv =====
`timescale 1ns / 1ps

// Restoring remainder, one dividend bit per cycle while busy, over all eight dividend bits.
module fbc_keymod (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [3:0] divisor,
  output logic       done,
  output logic [3:0] rem
);

  logic       busy_r, busy_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic [7:0] dvd_r, dvd_nxt;
  logic [3:0] rem_r, rem_nxt;
  logic [3:0] trial;
  logic [3:0] trial_red;

  // The partial remainder stays below the divisor (at most 7), so three bits shift up.
  assign trial     = {rem_r[2:0], dvd_r[7]};
  assign trial_red = (trial >= divisor) ? (trial - divisor) : trial;

  assign done = busy_r && (cnt_r == 3'd7);
  assign rem  = trial_red;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = 3'd0;
      dvd_nxt  = dividend;
      rem_nxt  = 4'd0;
    end else if (busy_r) begin
      cnt_nxt = cnt_r + 3'd1;
      dvd_nxt = {dvd_r[6:0], 1'b0};
      rem_nxt = trial_red;
      if (cnt_r == 3'd7) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

endmodule

// ===== sv/fbc_round.sv =====
`timescale 1ns / 1ps

// One Feistel round. Only the low 16 bits of the product survive the mask,
// so a 16 by 16 multiplier is enough.
module fbc_round (
  input  fbc_pkg::round_ctl_t         ctl,
  input  logic [fbc_pkg::HALF_W-1:0]  left,
  input  logic [fbc_pkg::HALF_W-1:0]  right,
  output logic [fbc_pkg::HALF_W-1:0]  new_left,
  output logic [fbc_pkg::HALF_W-1:0]  new_right
);

  logic [7:0]                 j_inc;
  logic [15:0]                mult;
  logic [31:0]                prod;
  logic [15:0]                f;
  logic [fbc_pkg::HALF_W-1:0] mixed;

  assign j_inc = ctl.j + 8'd1;
  assign mult  = ({{8{ctl.key_byte[7]}}, ctl.key_byte} ^ {8'd0, j_inc}) + 16'd2;
  assign prod  = left[15:0] * mult;
  assign f     = prod[15:0] & fbc_pkg::ROUND_MASK;
  assign mixed = right ^ {16'd0, f};

  always_comb begin
    if (ctl.last) begin
      new_left  = left;
      new_right = mixed;
    end else begin
      new_left  = mixed;
      new_right = left;
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam logic [fbc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_BLOCKS = 155;
  localparam int MAX_REPORTS = 20;

  typedef enum int {
    SEND_LIGHT,
    SEND_HEAVY,
    GAPS_OFF
  } gap_mode_t;

  typedef struct packed {
    logic                        op;
    logic [fbc_pkg::BLOCK_W-1:0] data;
  } block_req_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [fbc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fbc_pkg::KEY_W-1:0]     cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_operation = 1'b0;
  logic [fbc_pkg::BLOCK_W-1:0]   in_block_in = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [fbc_pkg::BLOCK_W-1:0]   out_block_out;

  // Register copies used by the cipher model.
  logic [fbc_pkg::KEY_W-1:0] key_shadow = '0;
  logic [3:0]                klen_shadow = fbc_pkg::KEY_LENGTH_RST;
  logic [7:0]                rounds_shadow = fbc_pkg::ROUND_COUNT_RST;

  block_req_t                  pending_blocks[$];
  logic [fbc_pkg::BLOCK_W-1:0] expected_blocks[$];
  block_req_t                  drive_req;
  logic [fbc_pkg::BLOCK_W-1:0] want_block;
  logic                        in_taken = 1'b0;
  gap_mode_t                   gap_mode = SEND_LIGHT;

  int err_count = 0;
  int result_count = 0;
  int encrypt_count = 0;
  int decrypt_count = 0;
  int setting_count = 0;

  feistel_block_cipher_64 dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .in_block_in  (in_block_in),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_block_out(out_block_out)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("testbench: errors");
    $finish;
  end

  function automatic logic [fbc_pkg::BLOCK_W-1:0] cipher_block(
      input logic op, input logic [fbc_pkg::BLOCK_W-1:0] blk);
    logic [fbc_pkg::HALF_W-1:0] left;
    logic [fbc_pkg::HALF_W-1:0] right;
    logic [fbc_pkg::HALF_W-1:0] swap;
    logic [fbc_pkg::HALF_W-1:0] mult;
    logic [fbc_pkg::HALF_W-1:0] prod;
    logic [fbc_pkg::HALF_W-1:0] f;
    logic [7:0]                 kbyte;
    int                         klen;
    int                         n;
    int                         j;
    int                         s;
    left = blk[fbc_pkg::BLOCK_W-1:fbc_pkg::HALF_W];
    right = blk[fbc_pkg::HALF_W-1:0];
    klen = klen_shadow;
    if (klen == 0) klen = 1;
    if (klen > fbc_pkg::MAX_KEY_BYTES_DEF) klen = fbc_pkg::MAX_KEY_BYTES_DEF;
    n = rounds_shadow;
    if (n > fbc_pkg::MAX_ROUNDS_DEF) n = fbc_pkg::MAX_ROUNDS_DEF;
    for (s = 0; s < n; s++) begin
      j = (op == fbc_pkg::OP_DECRYPT) ? (n - 1 - s) : s;
      kbyte = key_shadow[8 * (j % klen) +: 8];
      mult = ({{24{kbyte[7]}}, kbyte} ^ (j + 1)) + 2;
      prod = left * mult;
      f = {16'h0000, prod[15:0] & fbc_pkg::ROUND_MASK};
      if (s != n - 1) begin
        swap = left;
        left = f ^ right;
        right = swap;
      end else begin
        right = f ^ right;
      end
    end
    return {left, right};
  endfunction

  function automatic bit hold_off(input bit sender);
    int pct;
    case (gap_mode)
      SEND_LIGHT: pct = sender ? 24 : 57;
      SEND_HEAVY: pct = sender ? 57 : 24;
      default:    pct = 0;
    endcase
    return $urandom_range(0, 99) < pct;
  endfunction

  function automatic logic [fbc_pkg::BLOCK_W-1:0] random_block();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      3:       return {32'h0, $urandom()};
      4:       return {$urandom(), 32'h0};
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_count < MAX_REPORTS) $display("MISMATCH at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  task automatic push_block(input logic op, input logic [fbc_pkg::BLOCK_W-1:0] data);
    pending_blocks.push_back(block_req_t'{op: op, data: data});
  endtask

  task automatic wait_idle();
    while (pending_blocks.size() != 0 || in_valid || expected_blocks.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [fbc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fbc_pkg::KEY_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      fbc_pkg::REG_KEY_BYTES:   key_shadow = value;
      fbc_pkg::REG_KEY_LENGTH:  klen_shadow = value[3:0];
      fbc_pkg::REG_ROUND_COUNT: rounds_shadow = value[7:0];
      default: ;
    endcase
  endtask

  // The unused upper bits of the narrow registers carry random junk, which
  // the block must drop.
  task automatic configure(input logic [fbc_pkg::KEY_W-1:0] key, input logic [3:0] klen,
                           input logic [7:0] rounds);
    logic [fbc_pkg::KEY_W-1:0] junk;
    wait_idle();
    junk = {$urandom(), $urandom()};
    cfg_write(fbc_pkg::REG_KEY_BYTES, key);
    cfg_write(fbc_pkg::REG_KEY_LENGTH, {junk[fbc_pkg::KEY_W-1:4], klen});
    junk = {$urandom(), $urandom()};
    cfg_write(fbc_pkg::REG_ROUND_COUNT, {junk[fbc_pkg::KEY_W-1:8], rounds});
    if ($urandom_range(0, 3) == 0) cfg_write(REG_UNUSED, {$urandom(), $urandom()});
    setting_count++;
  endtask

  // Random traffic, with a share of encrypt/decrypt round trips.
  task automatic fill_random(input int count);
    logic [fbc_pkg::BLOCK_W-1:0] plain;
    int k;
    k = 0;
    while (k < count) begin
      plain = random_block();
      if ($urandom_range(0, 4) == 0) begin
        push_block(fbc_pkg::OP_ENCRYPT, plain);
        push_block(fbc_pkg::OP_DECRYPT, cipher_block(fbc_pkg::OP_ENCRYPT, plain));
        k += 2;
      end else begin
        push_block(logic'($urandom_range(0, 1)), plain);
        k++;
      end
    end
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (pending_blocks.size() != 0 && !hold_off(1'b1)) begin
        drive_req = pending_blocks.pop_front();
        in_operation <= drive_req.op;
        in_block_in <= drive_req.data;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ready <= rst_n && !hold_off(1'b0);
  end

  // The expectation is computed when the input transaction is accepted,
  // since the registers never change while a block is in flight.
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      expected_blocks.push_back(cipher_block(in_operation, in_block_in));
      if (in_operation == fbc_pkg::OP_DECRYPT) decrypt_count++;
      else encrypt_count++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (expected_blocks.size() == 0) begin
        report_mismatch($sformatf("result %h with no block outstanding", out_block_out));
      end else begin
        want_block = expected_blocks.pop_front();
        result_count++;
        if (out_block_out !== want_block)
          report_mismatch($sformatf("block_out %h, predicted %h", out_block_out, want_block));
      end
    end
  end

  initial begin
    logic [fbc_pkg::BLOCK_W-1:0] probe;
    logic [fbc_pkg::KEY_W-1:0]   key;
    logic [3:0]                  klen;
    logic [7:0]                  rounds;
    int                          count;
    int                          p;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset settings: zero key, one key byte, sixteen rounds.
    probe = 64'h0123_4567_89AB_CDEF;
    push_block(fbc_pkg::OP_ENCRYPT, '0);
    push_block(fbc_pkg::OP_ENCRYPT, '1);
    push_block(fbc_pkg::OP_DECRYPT, '1);
    push_block(fbc_pkg::OP_ENCRYPT, 64'h8000_0000_0000_0001);
    push_block(fbc_pkg::OP_ENCRYPT, probe);
    push_block(fbc_pkg::OP_DECRYPT, cipher_block(fbc_pkg::OP_ENCRYPT, probe));

    // Every key byte reads as minus one; a single round means no swap.
    configure('1, 4'd8, 8'd1);
    push_block(fbc_pkg::OP_ENCRYPT, probe);
    push_block(fbc_pkg::OP_DECRYPT, probe);
    push_block(fbc_pkg::OP_ENCRYPT, '1);

    // With zero rounds the block passes through.
    configure(64'h8080_8080_8080_8080, 4'd8, 8'd0);
    push_block(fbc_pkg::OP_ENCRYPT, probe);
    push_block(fbc_pkg::OP_DECRYPT, ~probe);

    // A key length of zero acts as one.
    configure(64'h7F80_7F80_7F80_7F80, 4'd0, 8'd3);
    push_block(fbc_pkg::OP_ENCRYPT, probe);
    push_block(fbc_pkg::OP_DECRYPT, probe);

    // Key lengths above eight saturate; the largest round count.
    configure({$urandom(), $urandom()}, 4'd15, 8'd255);
    push_block(fbc_pkg::OP_ENCRYPT, probe);
    push_block(fbc_pkg::OP_DECRYPT, cipher_block(fbc_pkg::OP_ENCRYPT, probe));

    // A write to the unused index must leave all registers alone.
    wait_idle();
    cfg_write(REG_UNUSED, '1);
    push_block(fbc_pkg::OP_ENCRYPT, probe);
    push_block(fbc_pkg::OP_DECRYPT, '0);

    for (p = 0; p < NUM_PHASES; p++) begin
      key = {$urandom(), $urandom()};
      klen = 4'($urandom_range(0, 15));
      rounds = 8'($urandom_range(2, 24));
      count = PHASE_BLOCKS;
      case (p)
        0: klen = 4'd8;
        1: klen = 4'd1;
        2: key = '0;
        3: begin
          rounds = 8'd255;
          count = 12;
        end
        5: rounds = 8'd1;
        6: key = 64'h8080_8080_8080_8080;
        7: begin
          rounds = 8'($urandom_range(200, 254));
          count = 15;
        end
        9: rounds = 8'd0;
        default: ;
      endcase
      configure(key, klen, rounds);
      gap_mode = gap_mode_t'(p * 3 / NUM_PHASES);
      fill_random(count);
    end

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Ran %0d blocks (%0d encrypt, %0d decrypt) over %0d register settings,",
             result_count, encrypt_count, decrypt_count, setting_count);
    $display("covering zero to 255 rounds, key lengths 0 to 15 and three idle patterns.");
    if (err_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
